>>> hdl/ebrd_pkg.sv
// ----------------------------------------------------------------------------
// ebrd_pkg
// shared types, constants and commands of the beat rate detector
// ----------------------------------------------------------------------------
`default_nettype none
package ebrd_pkg;
  localparam int AVG_DEPTH_DEF   = 5;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int THR_W  = 40;
  localparam int TIME_W = 32;
  localparam int RATE_W = 16;
  localparam int CFG_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_IBI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IBI = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd3;

  localparam logic [CFG_W-1:0]  MIN_THR_RST = 24'd1500;
  localparam logic [15:0]       MIN_IBI_RST = 16'd300;
  localparam logic [15:0]       MAX_IBI_RST = 16'd1500;
  localparam logic [15:0]       TIMEOUT_RST = 16'd3000;
  localparam logic [TIME_W-1:0] RATE_NUM    = 32'd60000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQUARE, ST_LOSS, ST_DECAY_DIV, ST_DECAY_SUB, ST_DETECT,
    ST_RATE_DIV, ST_RAISE, ST_SUM, ST_AVG_DIV, ST_AVG_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic loss;
    logic div_start_decay;
    logic decay_sub;
    logic detect;
    logic div_start_rate;
    logic raise;
    logic sum_clear;
    logic sum_step;
    logic div_start_avg;
    logic avg_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic off;
    logic div_busy;
    logic beat;
    logic sum_last;
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/ebrd_if.sv
// ----------------------------------------------------------------------------
// ebrd_in_if / ebrd_out_if
// valid/ready channels of the beat rate detector
// ----------------------------------------------------------------------------
`default_nettype none
interface ebrd_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [31:0]            time_ms;
  logic                   lead_off_plus;
  logic                   lead_off_minus;
  modport source (output valid, sample, time_ms, lead_off_plus, lead_off_minus,
                  input ready);
  modport sink   (input valid, sample, time_ms, lead_off_plus, lead_off_minus,
                  output ready);
endinterface

interface ebrd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] beats_per_minute;
  modport source (output valid, beats_per_minute, input ready);
  modport sink   (input valid, beats_per_minute, output ready);
endinterface
`default_nettype wire

>>> hdl/ebrd_div.sv
// ----------------------------------------------------------------------------
// ebrd_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module ebrd_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [39:0] dividend,
  input  wire logic [39:0] divisor,
  output logic             busy,
  output logic [39:0]      quotient
);
  import ebrd_pkg::*;
  logic [39:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [40:0] trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {r_r, q_r[39]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor; cnt_nxt = 6'd40;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[40]) begin
        r_nxt = trial[39:0];
        q_nxt = {q_r[38:0], 1'b1};
      end else begin
        r_nxt = {r_r[38:0], q_r[39]};
        q_nxt = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = q_r;
endmodule
`default_nettype wire

>>> hdl/ebrd_ctrl.sv
// ----------------------------------------------------------------------------
// ebrd_ctrl
// sequencer stepping one sample through the datapath
// ----------------------------------------------------------------------------
`default_nettype none
module ebrd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire ebrd_pkg::sts_t sts,
  output ebrd_pkg::cmd_t     cmd
);
  import ebrd_pkg::*;
  state_t state_r, state_nxt;
  logic   wait_r, wait_nxt;

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_SQUARE;
      ST_SQUARE:    state_nxt = sts.off ? ST_OUT : ST_LOSS;
      ST_LOSS:      state_nxt = ST_DECAY_DIV;
      ST_DECAY_DIV: begin
        wait_nxt = 1'b1;
        if (wait_r && !sts.div_busy) state_nxt = ST_DECAY_SUB;
      end
      ST_DECAY_SUB: state_nxt = ST_DETECT;
      ST_DETECT:    state_nxt = sts.beat ? ST_RATE_DIV : ST_OUT;
      ST_RATE_DIV:  begin
        wait_nxt = 1'b1;
        if (wait_r && !sts.div_busy) state_nxt = ST_RAISE;
      end
      ST_RAISE:     state_nxt = ST_SUM;
      ST_SUM:       if (sts.sum_last) state_nxt = ST_AVG_DIV;
      ST_AVG_DIV:   begin
        wait_nxt = 1'b1;
        if (wait_r && !sts.div_busy) state_nxt = ST_AVG_DONE;
      end
      ST_AVG_DONE:  state_nxt = ST_OUT;
      ST_OUT:       if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE:      begin in_ready = 1'b1; cmd.load = in_valid; end
      ST_SQUARE:    cmd.square = 1'b1;
      ST_LOSS:      cmd.loss = 1'b1;
      ST_DECAY_DIV: cmd.div_start_decay = !wait_r;
      ST_DECAY_SUB: cmd.decay_sub = 1'b1;
      ST_DETECT:    cmd.detect = 1'b1;
      ST_RATE_DIV:  cmd.div_start_rate = !wait_r;
      ST_RAISE:     begin cmd.raise = 1'b1; cmd.sum_clear = 1'b1; end
      ST_SUM:       cmd.sum_step = 1'b1;
      ST_AVG_DIV:   cmd.div_start_avg = !wait_r;
      ST_AVG_DONE:  cmd.avg_done = 1'b1;
      ST_OUT:       cmd.out_load = !out_valid || out_ready;
      default:      ;
    endcase
  end

  logic ov_r, ov_nxt;
  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if (cmd.out_load) ov_nxt = 1'b1;
  end
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; wait_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; wait_r <= wait_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

>>> hdl/ebrd_dp.sv
// ----------------------------------------------------------------------------
// ebrd_dp
// detector datapath: squaring, threshold, interval check, rate history
// ----------------------------------------------------------------------------
`default_nettype none
module ebrd_dp #(
  parameter int AVG_DEPTH   = ebrd_pkg::AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = ebrd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic [31:0]            in_time_ms,
  input  wire logic                   in_off,
  input  wire logic [23:0]            min_threshold,
  input  wire logic [15:0]            min_interval_ms,
  input  wire logic [15:0]            max_interval_ms,
  input  wire logic [15:0]            timeout_ms,
  input  wire ebrd_pkg::cmd_t         cmd,
  output ebrd_pkg::sts_t              sts,
  output logic [15:0]                 beats_per_minute
);
  import ebrd_pkg::*;
  localparam int IW = $clog2(AVG_DEPTH + 1);
  localparam int HW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SQW = 2 * SAMPLE_BITS;
  // ceil(2^48 / 100), exact floor division of values below 2^41 by 100
  localparam logic [41:0] RECIP_100 = 42'd2814749767107;

  logic [SAMPLE_BITS-1:0] smp_r, prev_r;
  logic [31:0]  now_r, last_r, ibi_r;
  logic         off_r, active_r, seen_r;
  logic [THR_W-1:0] thr_r;
  logic [SQW-1:0]   sq_r;
  logic [15:0]  rate_r, bpm_r;
  logic [15:0]  hist [AVG_DEPTH];
  logic [HW-1:0] hidx_r;
  logic [IW-1:0] hcnt_r, sidx_r;
  logic [19:0]  sum_r;
  logic [15:0]  hrd;

  logic [THR_W-1:0] fl;
  assign fl = {min_threshold, 16'd0};
  logic [THR_W+SQW-1:0] sqq;
  assign sqq = {{THR_W{1'b0}}, sq_r} << 16;
  logic [THR_W+SQW-1:0] thr_w;
  assign thr_w = {{SQW{1'b0}}, thr_r};
  logic signed [SAMPLE_BITS:0] dx;
  assign dx = $signed({1'b0, smp_r}) - $signed({1'b0, prev_r});
  logic [31:0] ibi;
  assign ibi = now_r - last_r;
  logic [THR_W+SQW-1:0] t_raise;
  assign t_raise = {{THR_W{1'b0}}, sq_r} << 15;
  logic beat;
  assign beat = sqq > thr_w && !active_r && seen_r && ibi != 32'd0 &&
                ibi >= {16'd0, min_interval_ms} && ibi <= {16'd0, max_interval_ms};

  logic        dv_start, dv_busy;
  logic [39:0] dv_a, dv_b, dv_q;

  // decay step ceil(x/100) as floor((x+99)/100) by reciprocal multiply
  logic [40:0] rc_y_r;
  logic [82:0] rc_acc_r;
  logic [1:0]  rc_k_r;
  logic        rc_busy_r;
  logic [13:0] rc_chunk;
  logic [54:0] rc_prod;

  always_comb begin
    case (rc_k_r)
      2'd2:    rc_chunk = RECIP_100[41:28];
      2'd1:    rc_chunk = RECIP_100[27:14];
      default: rc_chunk = RECIP_100[13:0];
    endcase
  end
  assign rc_prod = {14'd0, rc_y_r} * {41'd0, rc_chunk};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_busy_r <= 1'b0; rc_k_r <= '0;
    end else if (cmd.div_start_decay) begin
      rc_busy_r <= 1'b1; rc_k_r <= 2'd2;
    end else if (rc_busy_r) begin
      rc_k_r <= rc_k_r - 2'd1;
      if (rc_k_r == 2'd0) rc_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_decay) begin
      rc_y_r <= {1'b0, thr_r - fl} + 41'd99; rc_acc_r <= '0;
    end else if (rc_busy_r) begin
      rc_acc_r <= {rc_acc_r[68:0], 14'd0} + {28'd0, rc_prod};
    end
  end

  always_comb begin
    dv_start = cmd.div_start_rate | cmd.div_start_avg;
    dv_a = 40'd0; dv_b = 40'd1;
    if (cmd.div_start_rate)  begin dv_a = {8'd0, RATE_NUM}; dv_b = {8'd0, ibi_r}; end
    if (cmd.div_start_avg)   begin
      dv_a = {20'd0, sum_r}; dv_b = {{(40-IW){1'b0}}, hcnt_r};
    end
  end

  ebrd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
    .divisor(dv_b), .busy(dv_busy), .quotient(dv_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.raise) hist[hidx_r] <= dv_q[15:0];
    hrd <= hist[sidx_r[HW-1:0]];
  end

  logic sum_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0; thr_r <= {MIN_THR_RST, 16'd0}; active_r <= 1'b0;
      seen_r <= 1'b0; last_r <= '0; hidx_r <= '0; hcnt_r <= '0;
      rate_r <= '0; sum_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        smp_r <= in_sample; now_r <= in_time_ms; off_r <= in_off;
      end
      if (cmd.square) begin
        prev_r <= smp_r;
        sq_r   <= SQW'(dx * dx);
        if (off_r) begin
          rate_r <= '0; active_r <= 1'b0; seen_r <= 1'b0; last_r <= '0;
          thr_r <= fl; hcnt_r <= '0; hidx_r <= '0;
        end
      end
      if (cmd.loss && seen_r && ibi > {16'd0, timeout_ms}) begin
        rate_r <= '0; seen_r <= 1'b0; last_r <= '0; hcnt_r <= '0;
        hidx_r <= '0; thr_r <= fl;
      end
      if (cmd.decay_sub && thr_r > fl)
        thr_r <= thr_r - {5'd0, rc_acc_r[82:48]};
      if (cmd.detect) begin
        ibi_r <= ibi;
        if (sqq > thr_w && !active_r) begin
          active_r <= 1'b1;
          last_r <= now_r;
          seen_r <= 1'b1;
        end else if (sqq * 5 < thr_w * 2) begin
          active_r <= 1'b0;
        end
      end
      if (cmd.raise) begin
        if (t_raise < {{SQW{1'b0}}, fl}) thr_r <= fl;
        else if (t_raise > {{SQW{1'b0}}, {THR_W{1'b1}}}) thr_r <= '1;
        else thr_r <= t_raise[THR_W-1:0];
        hidx_r <= (hidx_r == HW'(AVG_DEPTH - 1)) ? '0 : hidx_r + 1'b1;
        if (hcnt_r < IW'(AVG_DEPTH)) hcnt_r <= hcnt_r + 1'b1;
      end
      sum_valid_r <= cmd.sum_step;
      if (cmd.avg_done) rate_r <= dv_q[15:0];
      if (cmd.out_load) bpm_r <= off_r ? 16'd0 : rate_r;
    end
    if (cmd.sum_clear) begin sum_r <= '0; sidx_r <= '0; end
    else if (cmd.sum_step) begin
      if (sidx_r < hcnt_r) sidx_r <= sidx_r + 1'b1;
      if (sum_valid_r) sum_r <= sum_r + {4'd0, hrd};
    end
  end

  // hrd is read registered from sidx; sadd counts the adds, the last when it reaches hcnt
  logic [IW-1:0] sadd_r;
  always_ff @(posedge clk) begin
    if (cmd.sum_clear) sadd_r <= '0;
    else if (sum_valid_r && cmd.sum_step) sadd_r <= sadd_r + 1'b1;
  end

  assign sts.off      = off_r;
  assign sts.div_busy = dv_busy | rc_busy_r;
  assign sts.beat     = beat;
  assign sts.sum_last = cmd.sum_step && sum_valid_r && (sadd_r + 1'b1 == hcnt_r);
  assign beats_per_minute = bpm_r;
endmodule
`default_nettype wire

>>> hdl/ecg_beat_rate_detector.sv
// ----------------------------------------------------------------------------
// ecg_beat_rate_detector
// squared-derivative QRS detector with adaptive threshold and rate averaging
// ----------------------------------------------------------------------------
// One sample is processed at a time and gives one rate result. A sample with
// a lead-off flag goes from squaring straight to the output; others pass the
// loss check, the threshold decay done by a reciprocal multiply and the
// detection, and when a beat is accepted, the shared divider for the
// 60000/interval rate, the walk over the history entries and the divider
// again for the history mean.
`default_nettype none
module ecg_beat_rate_detector #(
  parameter int AVG_DEPTH   = ebrd_pkg::AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = ebrd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ebrd_in_if.sink          in_ch,
  ebrd_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [ebrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ebrd_pkg::CFG_W-1:0]     cfg_data
);
  import ebrd_pkg::*;
  logic [23:0] min_thr_r;
  logic [15:0] min_ibi_r, max_ibi_r, timeout_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_thr_r <= MIN_THR_RST; min_ibi_r <= MIN_IBI_RST;
      max_ibi_r <= MAX_IBI_RST; timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_THR: min_thr_r <= cfg_data;
        REG_MIN_IBI: min_ibi_r <= cfg_data[15:0];
        REG_MAX_IBI: max_ibi_r <= cfg_data[15:0];
        REG_TIMEOUT: timeout_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ebrd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  ebrd_dp #(.AVG_DEPTH(AVG_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_sample(in_ch.sample), .in_time_ms(in_ch.time_ms),
    .in_off(in_ch.lead_off_plus | in_ch.lead_off_minus),
    .min_threshold(min_thr_r), .min_interval_ms(min_ibi_r),
    .max_interval_ms(max_ibi_r), .timeout_ms(timeout_r),
    .cmd(cmd), .sts(sts), .beats_per_minute(out_ch.beats_per_minute)
  );
endmodule
`default_nettype wire

>>> hdl/ecg_beat_rate_detector_chk.sv
// ----------------------------------------------------------------------------
// ecg_beat_rate_detector_chk
// port-level checks of the beat rate detector
// ----------------------------------------------------------------------------
`default_nettype none
module ecg_beat_rate_detector_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] bpm
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bpm)) else $error("hold");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bpm <= 16'd60000) else $error("range");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("one at a time");
endmodule

bind ecg_beat_rate_detector ecg_beat_rate_detector_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .bpm(out_ch.beats_per_minute)
);
`default_nettype wire

>>> tb/sv/ebrd_rate_checker.sv
// ----------------------------------------------------------------------------
// ebrd_rate_checker
// watches the sample and rate channels and the register port, predicts each
// averaged rate from its own copy of the detector state and compares it with
// the rate that comes out, oldest first
// ----------------------------------------------------------------------------
module ebrd_rate_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  ebrd_in_if                                smp_mon,
  ebrd_out_if                               bpm_mon,
  input  logic                              cfg_we,
  input  logic [ebrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ebrd_pkg::CFG_W-1:0]        cfg_data,
  output int                                mismatches,
  output int                                rates_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import ebrd_pkg::*;

  localparam int HIST_N = AVG_DEPTH_DEF;

  logic [CFG_W-1:0] floor_int;
  logic [15:0]      ibi_lo, ibi_hi, loss_ms;

  logic [11:0]      prev_smp;
  logic [63:0]      thr_q;
  logic             in_peak;
  logic             have_peak;
  logic [31:0]      peak_t;
  logic [15:0]      hist [HIST_N];
  int               hist_idx, hist_cnt;
  logic [15:0]      avg_rate;

  logic [15:0]      rate_q [$];

  initial mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic clear_tracking();
    avg_rate  = '0;
    in_peak   = 1'b0;
    have_peak = 1'b0;
    peak_t    = '0;
    thr_q     = 64'(floor_int) << 16;
    hist_cnt  = 0;
    hist_idx  = 0;
  endtask

  task automatic predict_rate(input logic [11:0] smp, input logic [31:0] now,
                              input logic off, output logic [15:0] bpm);
    int          dx;
    logic [63:0] sq, sqq, fl, t;
    logic [31:0] ibi, sum;
    fl = 64'(floor_int) << 16;
    if (off) begin
      clear_tracking();
      prev_smp = smp;
      bpm = '0;
    end else begin
      dx = int'(smp) - int'(prev_smp);
      prev_smp = smp;
      sq = 64'(dx * dx);
      sqq = sq << 16;
      if (have_peak && (now - peak_t) > 32'(loss_ms)) begin
        avg_rate  = '0;
        have_peak = 1'b0;
        peak_t    = '0;
        hist_cnt  = 0;
        hist_idx  = 0;
        thr_q     = fl;
      end
      if (thr_q > fl) thr_q = thr_q - (thr_q - fl + 64'd99) / 64'd100;
      if (sqq > thr_q && !in_peak) begin
        in_peak = 1'b1;
        if (have_peak) begin
          ibi = now - peak_t;
          if (ibi != 0 && ibi >= 32'(ibi_lo) && ibi <= 32'(ibi_hi)) begin
            hist[hist_idx] = 16'(RATE_NUM / ibi);
            hist_idx = (hist_idx + 1) % HIST_N;
            if (hist_cnt < HIST_N) hist_cnt++;
            sum = '0;
            for (int i = 0; i < hist_cnt; i++) sum += 32'(hist[i]);
            avg_rate = 16'(sum / 32'(hist_cnt));
            t = sq << 15;
            if (t < fl) t = fl;
            if (t > 64'hFF_FFFF_FFFF) t = 64'hFF_FFFF_FFFF;
            thr_q = t;
          end
        end
        peak_t = now;
        have_peak = 1'b1;
      end else if (sqq * 5 < thr_q * 2) begin
        in_peak = 1'b0;
      end
      bpm = avg_rate;
    end
  endtask

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      floor_int = MIN_THR_RST;
      ibi_lo    = MIN_IBI_RST;
      ibi_hi    = MAX_IBI_RST;
      loss_ms   = TIMEOUT_RST;
      prev_smp  = '0;
      clear_tracking();
      rate_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_THR: floor_int = cfg_data;
          REG_MIN_IBI: ibi_lo = cfg_data[15:0];
          REG_MAX_IBI: ibi_hi = cfg_data[15:0];
          REG_TIMEOUT: loss_ms = cfg_data[15:0];
          default: ;
        endcase
      end
      if (bpm_mon.valid && bpm_mon.ready) begin
        if (rate_q.size() == 0) begin
          report_mismatch($sformatf("rate %0d with none owed", bpm_mon.beats_per_minute));
        end else begin
          want = rate_q.pop_front();
          if (bpm_mon.beats_per_minute !== want)
            report_mismatch($sformatf("beats_per_minute %0d, predicted %0d",
                                      bpm_mon.beats_per_minute, want));
        end
      end
      if (smp_mon.valid && smp_mon.ready) begin
        predict_rate(smp_mon.sample, smp_mon.time_ms,
                     smp_mon.lead_off_plus | smp_mon.lead_off_minus, want);
        rate_q.push_back(want);
      end
    end
    rates_owed <= rate_q.size();
  end
endmodule

>>> tb/sv/tb_ecg_beat_rate_detector.sv
// ----------------------------------------------------------------------------
// tb_ecg_beat_rate_detector
// drives sample trains with spikes, lead-off events, signal loss and time
// wrap through several register settings, with random stalls on both sides;
// the checker predicts every rate and the top gives the verdict
// ----------------------------------------------------------------------------
module tb_ecg_beat_rate_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import ebrd_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_THR;
  logic [CFG_W-1:0] cfg_data = '0;
  int mismatches, rates_owed;
  bit idle_on = 1'b1;
  bit hold_long = 1'b0;
  int quiet_cycles = 0;
  logic [31:0] cur_t;

  ebrd_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
  ebrd_out_if out_ch ();

  ecg_beat_rate_detector i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ebrd_rate_checker i_checker (
    .clk(clk), .rst_n(rst_n), .smp_mon(in_ch), .bpm_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .rates_owed(rates_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.time_ms = '0;
    in_ch.lead_off_plus = 1'b0;
    in_ch.lead_off_minus = 1'b0;
    out_ch.ready = 1'b0;
  end

  // rate receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_sample(input logic [11:0] smp, input logic [31:0] t,
                             input logic lp, input logic lm);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.time_ms <= t;
    in_ch.lead_off_plus <= lp;
    in_ch.lead_off_minus <= lm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_rates();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rates_owed != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_regs(input logic [23:0] thr, input logic [15:0] lo,
                            input logic [15:0] hi, input logic [15:0] loss);
    cfg_we <= 1'b1; cfg_index <= REG_MIN_THR; cfg_data <= thr;
    @(posedge clk);
    cfg_index <= REG_MIN_IBI; cfg_data <= 24'(lo);
    @(posedge clk);
    cfg_index <= REG_MAX_IBI; cfg_data <= 24'(hi);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT; cfg_data <= 24'(loss);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // noisy baseline with spikes at random gaps, plus lead-off, loss and junk samples
  task automatic beat_train(input int n, input int hold_at);
    int base, gap;
    logic [11:0] s;
    logic lp, lm;
    base = $urandom_range(1200, 2500);
    gap = $urandom_range(12, 40);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_long = 1'b1;
      cur_t += $urandom_range(20, 40);
      if ($urandom_range(0, 119) == 0) cur_t += $urandom_range(3000, 70000);
      lp = 1'b0;
      lm = 1'b0;
      gap--;
      if (gap == 0) begin
        s = 12'(base + $urandom_range(200, 1500));
        gap = $urandom_range(12, 40);
      end else if ($urandom_range(0, 49) == 0) begin
        s = 12'($urandom);
      end else begin
        s = 12'(base + $urandom_range(0, 6));
      end
      if ($urandom_range(0, 79) == 0) begin
        lp = 1'($urandom);
        lm = !lp | 1'($urandom);
      end
      send_sample(s, cur_t, lp, lm);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_regs(MIN_THR_RST, MIN_IBI_RST, MAX_IBI_RST, TIMEOUT_RST);

    // directed: extremes, lead-off, first peak, zero and short interval,
    // accepted beat, signal loss, time wrap
    send_sample(12'hFFF, 32'd0, 1'b1, 1'b0);
    send_sample(12'h000, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_sample(12'hFFF, 32'd5, 1'b1, 1'b1);
    send_sample(12'h000, 32'd0, 1'b0, 1'b0);
    send_sample(12'hFFF, 32'd100, 1'b0, 1'b0);
    send_sample(12'hFFF, 32'd100, 1'b0, 1'b0);
    send_sample(12'h000, 32'd100, 1'b0, 1'b0);
    send_sample(12'h000, 32'd200, 1'b0, 1'b0);
    send_sample(12'hFFF, 32'd200, 1'b0, 1'b0);
    send_sample(12'hFFF, 32'd250, 1'b0, 1'b0);
    send_sample(12'h000, 32'd800, 1'b0, 1'b0);
    send_sample(12'h000, 32'd900, 1'b0, 1'b0);
    send_sample(12'h800, 32'd1500, 1'b0, 1'b0);
    send_sample(12'h800, 32'd1600, 1'b0, 1'b0);
    send_sample(12'h801, 32'd6000, 1'b0, 1'b0);
    send_sample(12'hA00, 32'hFFFF_FF00, 1'b0, 1'b0);
    send_sample(12'hA00, 32'hFFFF_FF80, 1'b0, 1'b0);
    send_sample(12'h555, 32'h0000_0200, 1'b0, 1'b0);
    send_sample(12'h555, 32'h0000_0280, 1'b0, 1'b0);
    send_sample(12'hAAA, 32'h0000_0500, 1'b0, 1'b0);
    drain_rates();

    cur_t = $urandom;
    beat_train(250, 120);
    drain_rates();

    write_regs(24'd0, 16'd1, 16'hFFFF, 16'hFFFF);
    cur_t = $urandom;
    beat_train(150, -1);
    drain_rates();

    write_regs(24'd16769025, 16'hFFFF, 16'd1, 16'd1);
    cur_t = $urandom;
    beat_train(80, -1);
    drain_rates();

    write_regs(24'($urandom_range(200, 5000)), 16'($urandom_range(250, 400)),
               16'($urandom_range(1200, 2000)), 16'($urandom_range(1000, 4000)));
    cur_t = $urandom;
    beat_train(120, -1);
    idle_on = 1'b0;
    beat_train(100, -1);
    drain_rates();

    if (mismatches == 0 && rates_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> filelist.f
hdl/ebrd_pkg.sv
hdl/ebrd_if.sv
hdl/ebrd_div.sv
hdl/ebrd_ctrl.sv
hdl/ebrd_dp.sv
hdl/ecg_beat_rate_detector.sv
hdl/ecg_beat_rate_detector_chk.sv
tb/sv/ebrd_rate_checker.sv
tb/sv/tb_ecg_beat_rate_detector.sv
